[hdl/pfcg_pkg.sv]
// ----------------------------------------------------------------------------
// pfcg_pkg
// Shared constants, types and tables for the peaking FIR coefficient generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfcg_pkg;

  localparam int unsigned TAP_W        = 11;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned COEF_W       = 32;
  localparam int unsigned MAX_ORDER    = 1024;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned LP_BITS      = 30;
  localparam int unsigned REM_W        = 11;
  localparam int unsigned QUO_W        = 32;
  localparam int unsigned CX_W         = 32;
  localparam int unsigned CZ_W         = 33;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned LANES        = 4;
  localparam int unsigned PIPE_DEPTH   = 1 + DIV_STEPS + 1 + CORDIC_STEPS + 2 + LP_BITS + 4;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] INV_PI_Q30  = 32'sd341782638;
  localparam logic signed [31:0] WIN_A0      = 32'sd450971566;
  localparam logic signed [31:0] WIN_A2      = 32'sd85899346;
  localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
  localparam logic signed [51:0] H_LIMIT     = 52'sd8589934591;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_ANGLE,
    REG_HALF_BAND_ANGLE,
    REG_FILTER_ORDER,
    REG_PEAK_GAIN
  } cfg_reg_e;

  typedef struct packed {
    logic [TAP_W-1:0] tap;
    logic             beyond;
    logic             mzero;
    logic             mneg;
    logic [9:0]       mabs;
  } side_t;

  typedef struct packed {
    logic signed [CZ_W-1:0] z;
    logic                   flip;
  } prerot_t;

  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

  // Folds a turn fraction into the right half plane of the rotator.
  function automatic prerot_t prerotate(input logic [31:0] a);
    prerot_t r;
    r.z    = $signed({a[31], a});
    r.flip = 1'b0;
    if (r.z > 33'sd1073741824) begin
      r.z    = r.z - 33'sd2147483648;
      r.flip = 1'b1;
    end else if (r.z < -33'sd1073741824) begin
      r.z    = r.z + 33'sd2147483648;
      r.flip = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/pfcg_div_cell.sv]
// ----------------------------------------------------------------------------
// pfcg_div_cell
// One registered restoring division step: shifts in a dividend bit and
// produces one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcg_div_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pfcg_pkg::REM_W-1:0]  rem_i,
  input  logic                        bit_i,
  input  logic [pfcg_pkg::REM_W-1:0]  div_i,
  input  logic [pfcg_pkg::QUO_W-1:0]  quo_i,
  output logic [pfcg_pkg::REM_W-1:0]  rem_o,
  output logic [pfcg_pkg::QUO_W-1:0]  quo_o
);
  import pfcg_pkg::*;

  logic [REM_W:0]   shifted;
  logic             fits;
  logic [REM_W:0]   diff;
  logic [REM_W-1:0] rem_d, rem_q;
  logic [QUO_W-1:0] quo_d, quo_q;

  assign shifted = {rem_i, bit_i};
  assign fits    = shifted >= {1'b0, div_i};
  assign diff    = shifted - {1'b0, div_i};
  assign rem_d   = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
  assign quo_d   = {quo_i[QUO_W-2:0], fits};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

[hdl/pfcg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// pfcg_cordic_cell
// One registered CORDIC rotation step with floor shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcg_cordic_cell (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [pfcg_pkg::STEP_W-1:0]       step_i,
  input  logic signed [pfcg_pkg::CX_W-1:0]  x_i,
  input  logic signed [pfcg_pkg::CX_W-1:0]  y_i,
  input  logic signed [pfcg_pkg::CZ_W-1:0]  z_i,
  output logic signed [pfcg_pkg::CX_W-1:0]  x_o,
  output logic signed [pfcg_pkg::CX_W-1:0]  y_o,
  output logic signed [pfcg_pkg::CZ_W-1:0]  z_o
);
  import pfcg_pkg::*;

  logic signed [CX_W-1:0] x_sh, y_sh, x_d, y_d, x_q, y_q;
  logic signed [CZ_W-1:0] ang, z_d, z_q;

  assign x_sh = x_i >>> step_i;
  assign y_sh = y_i >>> step_i;
  assign ang  = $signed({3'b000, atan_turn(step_i)});

  always_comb begin
    if (z_i >= 0) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - ang;
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

[hdl/peaking_fir_coefficient_generator.sv]
// ----------------------------------------------------------------------------
// peaking_fir_coefficient_generator
// Computes one Blackman-windowed FIR peaking equalizer tap per transaction.
// The cfg channel writes center angle, half band angle, filter order and
// peak gain by register index; it is always ready and should only be used
// while no transaction is in flight. The input channel takes a tap index and
// the output channel returns the Q4.28 coefficient, the tap number and a flag
// for indices beyond the order. One transaction is accepted per cycle while
// in_ready_o is high; each passes in turn through the two 32-cell phase
// dividers, the 24-cell CORDIC lanes, the 30-cell lowpass divider and the
// multiply stages. Reset restores the default settings and empties the
// pipeline. When the receiver stalls with a result waiting, the pipeline
// keeps moving until its last stage is full, then holds and drops in_ready_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peaking_fir_coefficient_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pfcg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfcg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pfcg_pkg::TAP_W-1:0]          tap_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pfcg_pkg::COEF_W-1:0]  coefficient_o,
  output logic [pfcg_pkg::TAP_W-1:0]          tap_number_o,
  output logic                                beyond_order_o
);
  import pfcg_pkg::*;

  logic [ANGLE_W-1:0] center_angle_q, half_band_angle_q;
  logic [TAP_W-1:0]   filter_order_q;
  logic [GAIN_W-1:0]  peak_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_angle_q    <= 16'd21845;
      half_band_angle_q <= 16'd1365;
      filter_order_q    <= 11'd576;
      peak_gain_q       <= 16'd4596;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_ANGLE:    center_angle_q    <= cfg_data_i;
        REG_HALF_BAND_ANGLE: half_band_angle_q <= cfg_data_i;
        REG_FILTER_ORDER:    filter_order_q    <= cfg_data_i[TAP_W-1:0];
        REG_PEAK_GAIN:       peak_gain_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  out_valid_q;
  logic                  adv;

  assign adv        = !out_valid_q || out_ready_i || !vld_q[PIPE_DEPTH-1];
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // Input decode.
  logic [TAP_W-1:0]  ord;
  logic signed [11:0] m_in;
  logic [11:0]       m_abs;
  logic [16:0]       ph_lo, pc_lo;
  logic [11:0]       two_n, red1, red2;
  logic [31:0]       half_word;
  side_t             side_in;

  assign ord   = (filter_order_q > TAP_W'(MAX_ORDER)) ? TAP_W'(MAX_ORDER) : filter_order_q;
  assign m_in  = $signed({1'b0, tap_index_i}) - $signed({2'b00, ord[10:1]});
  assign m_abs = m_in[11] ? 12'(-m_in) : 12'(m_in);
  assign ph_lo = 17'(half_band_angle_q * 17'({{5{m_in[11]}}, m_in}));
  assign pc_lo = 17'(center_angle_q * 17'({{5{m_in[11]}}, m_in}));
  assign two_n = {tap_index_i, 1'b0};
  assign red1  = (two_n >= {1'b0, ord}) ? two_n - {1'b0, ord} : two_n;
  assign red2  = (red1 >= {1'b0, ord}) ? red1 - {1'b0, ord} : red1;
  assign half_word = {22'd0, ord[10:1]};

  assign side_in.tap    = tap_index_i;
  assign side_in.beyond = tap_index_i > ord;
  assign side_in.mzero  = m_in == 12'sd0;
  assign side_in.mneg   = m_in[11];
  assign side_in.mabs   = m_abs[9:0];

  // Window phase divider row.
  logic [REM_W-1:0] p1_r1_q, p1_r2_q;
  side_t            ds_side_q [DIV_STEPS+1];
  logic [31:0]      ds_ph_q   [DIV_STEPS+1];
  logic [31:0]      ds_pc_q   [DIV_STEPS+1];
  logic             ds_ordz_q [DIV_STEPS+1];
  logic [REM_W-1:0] d_r1 [DIV_STEPS+1];
  logic [REM_W-1:0] d_r2 [DIV_STEPS+1];
  logic [QUO_W-1:0] d_q1 [DIV_STEPS+1];
  logic [QUO_W-1:0] d_q2 [DIV_STEPS+1];

  assign d_r1[0] = p1_r1_q;
  assign d_r2[0] = p1_r2_q;
  assign d_q1[0] = '0;
  assign d_q2[0] = '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_r1_q      <= (tap_index_i == ord) ? '0 : tap_index_i;
      p1_r2_q      <= red2[REM_W-1:0];
      ds_side_q[0] <= side_in;
      ds_ph_q[0]   <= {ph_lo, 15'd0};
      ds_pc_q[0]   <= {pc_lo, 15'd0};
      ds_ordz_q[0] <= ord == '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        ds_side_q[k+1] <= ds_side_q[k];
        ds_ph_q[k+1]   <= ds_ph_q[k];
        ds_pc_q[k+1]   <= ds_pc_q[k];
        ds_ordz_q[k+1] <= ds_ordz_q[k];
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    pfcg_div_cell u_cell1 (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (d_r1[k]),
      .bit_i (half_word[DIV_STEPS-1-k]),
      .div_i (ord),
      .quo_i (d_q1[k]),
      .rem_o (d_r1[k+1]),
      .quo_o (d_q1[k+1])
    );
    pfcg_div_cell u_cell2 (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (d_r2[k]),
      .bit_i (half_word[DIV_STEPS-1-k]),
      .div_i (ord),
      .quo_i (d_q2[k]),
      .rem_o (d_r2[k+1]),
      .quo_o (d_q2[k+1])
    );
  end

  // CORDIC row, four lanes: lowpass sine, center cosine, two window cosines.
  logic [31:0]            lane_ang [LANES];
  prerot_t                pr       [LANES];
  logic signed [CZ_W-1:0] cz0_q    [LANES];
  side_t                  cs_side_q [CORDIC_STEPS+1];
  logic [LANES-1:0]       cs_flip_q [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] c_x [LANES][CORDIC_STEPS+1];
  logic signed [CX_W-1:0] c_y [LANES][CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] c_z [LANES][CORDIC_STEPS+1];

  assign lane_ang[0] = ds_ph_q[DIV_STEPS];
  assign lane_ang[1] = ds_pc_q[DIV_STEPS];
  assign lane_ang[2] = ds_ordz_q[DIV_STEPS] ? '0 : d_q1[DIV_STEPS];
  assign lane_ang[3] = ds_ordz_q[DIV_STEPS] ? '0 : d_q2[DIV_STEPS];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pr[l] = prerotate(lane_ang[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cs_side_q[0] <= ds_side_q[DIV_STEPS];
      for (int l = 0; l < LANES; l++) begin
        cz0_q[l]        <= pr[l].z;
        cs_flip_q[0][l] <= pr[l].flip;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        cs_side_q[k+1] <= cs_side_q[k];
        cs_flip_q[k+1] <= cs_flip_q[k];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign c_x[l][0] = CORDIC_GAIN;
    assign c_y[l][0] = '0;
    assign c_z[l][0] = cz0_q[l];
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      pfcg_cordic_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .step_i (STEP_W'(k)),
        .x_i    (c_x[l][k]),
        .y_i    (c_y[l][k]),
        .z_i    (c_z[l][k]),
        .x_o    (c_x[l][k+1]),
        .y_o    (c_y[l][k+1]),
        .z_o    (c_z[l][k+1])
      );
    end
  end

  logic signed [CX_W-1:0] sv, cw_c, c1_c, c2_c;
  logic [LANES-1:0]       flip_end;

  assign flip_end = cs_flip_q[CORDIC_STEPS];
  assign sv   = flip_end[0] ? -c_y[0][CORDIC_STEPS] : c_y[0][CORDIC_STEPS];
  assign cw_c = flip_end[1] ? -c_x[1][CORDIC_STEPS] : c_x[1][CORDIC_STEPS];
  assign c1_c = flip_end[2] ? -c_x[2][CORDIC_STEPS] : c_x[2][CORDIC_STEPS];
  assign c2_c = flip_end[3] ? -c_x[3][CORDIC_STEPS] : c_x[3][CORDIC_STEPS];

  // Products after the rotator.
  logic signed [63:0] e1_prod_q, e1_t2_q;
  logic signed [31:0] e1_cw_q, e1_c1_q;
  side_t              e1_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_prod_q <= sv * INV_PI_Q30;
      e1_t2_q   <= c2_c * WIN_A2;
      e1_cw_q   <= cw_c;
      e1_c1_q   <= c1_c;
      e1_side_q <= cs_side_q[CORDIC_STEPS];
    end
  end

  logic [63:0]        mag, xs;
  logic signed [32:0] c1_half;
  logic signed [63:0] t2_r;
  logic signed [33:0] w_sum;
  logic signed [31:0] w_lim;

  assign mag     = e1_prod_q[63] ? -e1_prod_q : e1_prod_q;
  assign xs      = mag + {25'd0, e1_side_q.mabs, 29'd0};
  assign c1_half = ($signed({e1_c1_q[31], e1_c1_q}) + 33'sd1) >>> 1;
  assign t2_r    = (e1_t2_q + 64'sd536870912) >>> 30;
  assign w_sum   = 34'(WIN_A0) - 34'(c1_half) + 34'(t2_r);
  assign w_lim   = (w_sum > 34'(Q30_ONE)) ? Q30_ONE :
                   (w_sum < -34'(Q30_ONE)) ? -Q30_ONE : 32'(w_sum);

  // Lowpass divider row.
  logic [LP_BITS-1:0] ls_x_q    [LP_BITS+1];
  logic               ls_neg_q  [LP_BITS+1];
  logic signed [31:0] ls_cw_q   [LP_BITS+1];
  logic signed [31:0] ls_w_q    [LP_BITS+1];
  side_t              ls_side_q [LP_BITS+1];
  logic [REM_W-1:0]   l_rem [LP_BITS+1];
  logic [QUO_W-1:0]   l_quo [LP_BITS+1];

  assign l_rem[0] = '0;
  assign l_quo[0] = '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ls_x_q[0]    <= xs[59:30];
      ls_neg_q[0]  <= e1_prod_q[63] ^ e1_side_q.mneg;
      ls_cw_q[0]   <= e1_cw_q;
      ls_w_q[0]    <= w_lim;
      ls_side_q[0] <= e1_side_q;
      for (int k = 0; k < LP_BITS; k++) begin
        ls_x_q[k+1]    <= ls_x_q[k];
        ls_neg_q[k+1]  <= ls_neg_q[k];
        ls_cw_q[k+1]   <= ls_cw_q[k];
        ls_w_q[k+1]    <= ls_w_q[k];
        ls_side_q[k+1] <= ls_side_q[k];
      end
    end
  end

  for (genvar k = 0; k < LP_BITS; k++) begin : g_lp
    pfcg_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (l_rem[k]),
      .bit_i (ls_x_q[k][LP_BITS-1-k]),
      .div_i ({1'b0, ls_side_q[k].mabs}),
      .quo_i (l_quo[k]),
      .rem_o (l_rem[k+1]),
      .quo_o (l_quo[k+1])
    );
  end

  side_t              lp_side;
  logic [31:0]        q_ext;
  logic signed [31:0] lp, cw_eff;

  assign lp_side = ls_side_q[LP_BITS];
  assign q_ext   = {2'b00, l_quo[LP_BITS][LP_BITS-1:0]};
  assign lp      = lp_side.mzero ? $signed({2'b00, half_band_angle_q, 14'd0}) :
                   ls_neg_q[LP_BITS] ? -$signed(q_ext) : $signed(q_ext);
  assign cw_eff  = lp_side.mzero ? Q30_ONE : ls_cw_q[LP_BITS];

  // Tap assembly and windowing.
  logic signed [63:0] f1_bpf_q;
  logic signed [31:0] f1_w_q, f2_w_q, f3_w_q;
  side_t              f1_side_q, f2_side_q, f3_side_q, f4_side_q;
  logic signed [63:0] bp_r;
  logic signed [34:0] f2_bp_q;
  logic signed [51:0] f2_g_q;
  logic signed [51:0] rg, hsum, hr, hcl;
  logic signed [33:0] f3_h_q;
  logic signed [48:0] f4_phi_q;
  logic signed [49:0] f4_plo_q;

  assign bp_r = (f1_bpf_q + 64'sd268435456) >>> 29;
  assign rg   = (f2_g_q + 52'sd2048) >>> 12;
  assign hsum = rg - 52'(f2_bp_q) + (f2_side_q.mzero ? 52'(Q30_ONE) : 52'sd0);
  assign hr   = (hsum + 52'sd2) >>> 2;
  assign hcl  = (hr > H_LIMIT) ? H_LIMIT : (hr < -H_LIMIT) ? -H_LIMIT : hr;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_bpf_q  <= cw_eff * lp;
      f1_w_q    <= ls_w_q[LP_BITS];
      f1_side_q <= lp_side;
      f2_bp_q   <= bp_r[34:0];
      f2_g_q    <= $signed({1'b0, peak_gain_q}) * $signed(bp_r[34:0]);
      f2_w_q    <= f1_w_q;
      f2_side_q <= f1_side_q;
      f3_h_q    <= 34'(hcl);
      f3_w_q    <= f2_w_q;
      f3_side_q <= f2_side_q;
      f4_phi_q  <= $signed(f3_h_q[33:17]) * f3_w_q;
      f4_plo_q  <= $signed({1'b0, f3_h_q[16:0]}) * f3_w_q;
      f4_side_q <= f3_side_q;
    end
  end

  logic signed [67:0] prod_sum, prod_r;
  logic signed [31:0] coef_sat;

  assign prod_sum = (68'(f4_phi_q) <<< 17) + 68'(f4_plo_q);
  assign prod_r   = (prod_sum + 68'sd536870912) >>> 30;
  assign coef_sat = (prod_r > 68'sd2147483647) ? 32'sh7FFFFFFF :
                    (prod_r < -68'sd2147483648) ? 32'sh80000000 : 32'(prod_r);

  // Output register.
  logic signed [COEF_W-1:0] coef_q;
  logic [TAP_W-1:0]         tap_q;
  logic                     beyond_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      coef_q   <= f4_side_q.beyond ? '0 : coef_sat;
      tap_q    <= f4_side_q.tap;
      beyond_q <= f4_side_q.beyond;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coefficient_o  = coef_q;
  assign tap_number_o   = tap_q;
  assign beyond_order_o = beyond_q;

`ifndef SYNTHESIS
  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beyond_order_o |-> coefficient_o == '0)
    else $error("Out-of-range tap produced a nonzero coefficient.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled without a blocked output.");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !beyond_order_o |-> tap_number_o <= TAP_W'(MAX_ORDER))
    else $error("In-range tap number exceeds the maximum order.");
`endif

endmodule

`default_nettype wire
